/* hdl/djps_pkg.sv */
// djps_pkg: request, response and job types, phase and state enums, status codes
// shared by every module of the page size scanner; depends on nothing
package djps_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] page_number;
      logic [30:0] page_width;
      logic [30:0] page_height;
      logic        final_page;
   } rsp_type;

   // one queued piece of work: an error to report or a page to scale
   typedef struct packed {
      logic        is_page;
      logic [2:0]  status;
      logic [15:0] page_number;
      logic [15:0] dim_a;
      logic [15:0] dim_b;
      logic [15:0] dpi;
      logic [10:0] ref_dpi;
      logic        final_page;
   } job_type;

   typedef enum logic [1:0] {PH_SIG, PH_HDR, PH_INFO, PH_DONE} phase_type;

   typedef enum logic [1:0] {BK_IDLE, BK_MUL, BK_DIV, BK_OUT} back_state_type;

   localparam logic [2:0] ST_PAGE      = 3'd0;
   localparam logic [2:0] ST_BAD_SIG   = 3'd1;
   localparam logic [2:0] ST_NEG_LEN   = 3'd2;
   localparam logic [2:0] ST_EARLY_END = 3'd3;
   localparam logic [2:0] ST_ZERO_DPI  = 3'd4;
   localparam logic [2:0] ST_SHORT     = 3'd5;

   localparam logic [0:0] REG_PAGE_COUNT = 1'b0;
   localparam logic [0:0] REG_REF_DPI    = 1'b1;

   localparam logic [31:0] TAG_MAGIC = 32'h41542654;
   localparam logic [31:0] TAG_FORM  = 32'h464F524D;
   localparam logic [31:0] TAG_DJVM  = 32'h444A564D;
   localparam logic [31:0] TAG_DJVU  = 32'h444A5655;
   localparam logic [31:0] TAG_INFO  = 32'h494E464F;

   localparam logic [31:0] SIG_LAST_POS = 32'd15;
   localparam logic [31:0] MIN_PAGE_LEN = 32'd22;

endpackage

/* hdl/djvu_page_size_scanner.sv */
// djvu_page_size_scanner: top level with configuration registers, scanner,
// job queue and divider; depends on djps_pkg, djps_front, djps_queue, djps_back
//
//   channel   direction  handshake              payload
//   req_      in         req_valid/req_ready    req_data  (data_byte, last_byte)
//   rsp_      out        rsp_valid/rsp_ready    rsp_data  (status .. final_page)
//   csr_      in         csr_valid/csr_ready    csr_index, csr_data
//
// one request is taken per cycle while the job queue has room
// a page result needs one multiply and a 31-bit quotient in the divider for each
// dimension; an error result goes from the queue straight to the response register
// synchronous active high reset; no clearing pass, the byte window is a shift line
// a stalled response holds the divider, four queued jobs then stall requests
module djvu_page_size_scanner (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  djps_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output djps_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data
);
   import djps_pkg::*;

   // configuration, to be written only while idle; the block does not enforce this
   logic [15:0] page_count_ff;
   logic [10:0] ref_dpi_ff;

   // front to queue and queue to back
   logic    push, full, pop, not_empty;
   job_type push_job, pop_job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_count_ff <= 16'd1;
         ref_dpi_ff    <= 11'd300;
      end else if (csr_valid && csr_index[1] == 1'b0) begin
         // indexes beyond the list are accepted and dropped
         unique case (csr_index[0])
            REG_PAGE_COUNT: page_count_ff <= csr_data;
            REG_REF_DPI:    ref_dpi_ff    <= csr_data[10:0];
            default: ;
         endcase
      end
   end

   djps_front u_front (
      .clock         (clock),
      .reset         (reset),
      .byte_valid    (req_valid),
      .byte_ready    (req_ready),
      .byte_data     (req_data),
      .page_count    (page_count_ff),
      .reference_dpi (ref_dpi_ff),
      .job_full      (full),
      .job_push      (push),
      .job_data      (push_job)
   );

   djps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_data  (pop_job)
   );

   djps_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (not_empty),
      .job_data  (pop_job),
      .job_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* hdl/djps_front.sv */
// djps_front: byte scanner that checks the signature, walks chunk headers and
// turns pages and errors into jobs; depends on djps_pkg
module djps_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               byte_valid,
   output logic               byte_ready,
   input  djps_pkg::req_type  byte_data,
   input  logic [15:0]        page_count,
   input  logic [10:0]        reference_dpi,
   input  logic               job_full,
   output logic               job_push,
   output djps_pkg::job_type  job_data
);
   import djps_pkg::*;

   logic [7:0]  sh_ff [15];
   logic [7:0]  sh_in [15];
   logic [7:0]  cur [16];
   logic [31:0] pos_ff, pos_in;
   logic [31:0] tgt_ff, tgt_in;
   logic [31:0] len_ff, len_in;
   logic [15:0] pf_ff, pf_in;
   phase_type   phase_ff, phase_in;
   logic        acc;
   logic [31:0] w_magic, w_form, w_djvm, w_id, w_len, w_sub, w_chunk;
   logic [33:0] nxt;
   logic [15:0] pw, ph, dpi;
   logic [7:0]  flags;
   logic        fin, done;

   assign byte_ready = !job_full;
   assign acc        = byte_valid && byte_ready;

   always_comb begin
      cur[0] = byte_data.data_byte;
      for (int i = 1; i < 16; i++) cur[i] = sh_ff[i-1];
   end

   assign w_magic = {cur[15], cur[14], cur[13], cur[12]};
   assign w_form  = {cur[11], cur[10], cur[9], cur[8]};
   assign w_djvm  = {cur[3], cur[2], cur[1], cur[0]};
   assign w_id    = w_magic;
   assign w_len   = w_form;
   assign w_sub   = {cur[7], cur[6], cur[5], cur[4]};
   assign w_chunk = w_djvm;
   assign pw      = {cur[9], cur[8]};
   assign ph      = {cur[7], cur[6]};
   assign dpi     = {cur[2], cur[3]};
   assign flags   = cur[0];
   assign fin     = ({1'b0, pf_ff} + 17'd1) >= {1'b0, page_count};

   always_comb begin
      for (int i = 0; i < 15; i++) sh_in[i] = acc ? cur[i] : sh_ff[i];
      pos_in   = pos_ff;
      tgt_in   = tgt_ff;
      len_in   = len_ff;
      pf_in    = pf_ff;
      phase_in = phase_ff;
      job_push = 1'b0;
      job_data = '0;
      job_data.page_number = pf_ff;
      job_data.ref_dpi     = reference_dpi;
      nxt      = '0;
      done     = 1'b0;
      if (acc) begin
         if (pos_ff != 32'hFFFF_FFFF) pos_in = pos_ff + 32'd1;
         unique case (phase_ff)
            PH_SIG: begin
               if (pos_ff == SIG_LAST_POS) begin
                  if (w_magic != TAG_MAGIC || w_form != TAG_FORM) begin
                     job_push = 1'b1;
                     job_data.status = ST_BAD_SIG;
                     phase_in = PH_DONE;
                  end else begin
                     tgt_in   = (w_djvm == TAG_DJVM) ? 32'd31 : 32'd19;
                     phase_in = (pf_ff >= page_count) ? PH_DONE : PH_HDR;
                  end
               end
            end
            PH_HDR: begin
               if (pos_ff == tgt_ff) begin
                  // header start is tgt - 15, next header at start + 8 + len + pad
                  nxt = {2'b0, tgt_ff} - 34'd7 + {2'b0, w_len} + {33'b0, w_len[0]};
                  if (pf_ff >= page_count) begin
                     phase_in = PH_DONE;
                  end else if (w_len[31]) begin
                     job_push = 1'b1;
                     job_data.status = ST_NEG_LEN;
                     phase_in = PH_DONE;
                  end else if (w_id == TAG_FORM && w_sub == TAG_DJVU && w_chunk == TAG_INFO) begin
                     if (w_len < MIN_PAGE_LEN) begin
                        job_push = 1'b1;
                        job_data.status = ST_SHORT;
                        phase_in = PH_DONE;
                     end else begin
                        len_in   = w_len;
                        tgt_in   = tgt_ff + 32'd14;
                        phase_in = PH_INFO;
                     end
                  end else if (nxt + 34'd30 > 34'h0_FFFF_FFFF) begin
                     job_push = 1'b1;
                     job_data.status = ST_EARLY_END;
                     phase_in = PH_DONE;
                  end else begin
                     tgt_in = nxt[31:0] + 32'd15;
                  end
               end
            end
            PH_INFO: begin
               if (pos_ff == tgt_ff) begin
                  nxt = {2'b0, tgt_ff} - 34'd21 + {2'b0, len_ff} + {33'b0, len_ff[0]};
                  job_push = 1'b1;
                  phase_in = PH_DONE;
                  if (dpi == 16'd0) begin
                     job_data.status = ST_ZERO_DPI;
                  end else if (nxt + 34'd30 > 34'h0_FFFF_FFFF) begin
                     job_data.status = ST_EARLY_END;
                  end else begin
                     job_data.is_page    = 1'b1;
                     job_data.status     = ST_PAGE;
                     job_data.dim_a      = flags[2] ? ph : pw;
                     job_data.dim_b      = flags[2] ? pw : ph;
                     job_data.dpi        = dpi;
                     job_data.final_page = fin;
                     pf_in  = pf_ff + 16'd1;
                     tgt_in = nxt[31:0] + 32'd15;
                     if (!fin) phase_in = PH_HDR;
                  end
               end
            end
            PH_DONE: ;
            default: ;
         endcase
         if (byte_data.last_byte) begin
            done = (phase_in == PH_DONE) || (phase_in != PH_SIG && pf_in >= page_count);
            if (!done) begin
               // early end replaces a non-final page of the same request
               job_push = 1'b1;
               job_data = '0;
               job_data.status      = ST_EARLY_END;
               job_data.page_number = pf_in;
            end
            pos_in   = '0;
            tgt_in   = '0;
            pf_in    = '0;
            phase_in = PH_SIG;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         tgt_ff   <= '0;
         pf_ff    <= '0;
         phase_ff <= PH_SIG;
      end else begin
         pos_ff   <= pos_in;
         tgt_ff   <= tgt_in;
         pf_ff    <= pf_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      for (int i = 0; i < 15; i++) sh_ff[i] <= sh_in[i];
   end

endmodule

/* hdl/djps_queue.sv */
// djps_queue: four-entry job queue between scanner and divider
// depends on djps_pkg
module djps_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  djps_pkg::job_type  push_data,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output djps_pkg::job_type  pop_data
);
   import djps_pkg::*;

   job_type    mem_ff [4];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;

   assign full      = cnt_ff == 3'd4;
   assign not_empty = cnt_ff != 3'd0;
   assign pop_data  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 2'd1 : wr_ff;
      rd_in  = pop ? rd_ff + 2'd1 : rd_ff;
      cnt_in = cnt_ff + {2'b0, push} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule

/* hdl/djps_back.sv */
// djps_back: scales page sizes with one multiply and a bit-serial divider,
// holds the response register; depends on djps_pkg
module djps_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  djps_pkg::job_type  job_data,
   output logic               job_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output djps_pkg::rsp_type  rsp_data
);
   import djps_pkg::*;

   back_state_type state_ff, state_in;
   job_type     job_ff, job_in;
   logic [30:0] dvd_ff, dvd_in, quo_ff, quo_in, wq_ff, wq_in;
   logic [15:0] rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        second_ff, second_in;
   rsp_type     rsp_ff, rsp_in;
   logic [16:0] trial;
   logic [26:0] prod;

   assign rsp_valid = state_ff == BK_OUT;
   assign rsp_data  = rsp_ff;
   assign prod  = {16'b0, job_ff.ref_dpi} * {11'b0, second_ff ? job_ff.dim_b : job_ff.dim_a};
   assign trial = {rem_ff, dvd_ff[30]};

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      dvd_in    = dvd_ff;
      quo_in    = quo_ff;
      wq_in     = wq_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      second_in = second_ff;
      rsp_in    = rsp_ff;
      job_pop   = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               job_pop   = 1'b1;
               job_in    = job_data;
               second_in = 1'b0;
               if (job_data.is_page) begin
                  state_in = BK_MUL;
               end else begin
                  rsp_in = '0;
                  rsp_in.status      = job_data.status;
                  rsp_in.page_number = job_data.page_number;
                  state_in = BK_OUT;
               end
            end
         end
         BK_MUL: begin
            dvd_in   = {prod, 4'b0};
            rem_in   = '0;
            quo_in   = '0;
            cnt_in   = 5'd30;
            state_in = BK_DIV;
         end
         BK_DIV: begin
            dvd_in = {dvd_ff[29:0], 1'b0};
            if (trial >= {1'b0, job_ff.dpi}) begin
               rem_in = 16'(trial - {1'b0, job_ff.dpi});
               quo_in = {quo_ff[29:0], 1'b1};
            end else begin
               rem_in = trial[15:0];
               quo_in = {quo_ff[29:0], 1'b0};
            end
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               if (!second_ff) begin
                  wq_in     = quo_in;
                  second_in = 1'b1;
                  state_in  = BK_MUL;
               end else begin
                  rsp_in.status      = ST_PAGE;
                  rsp_in.page_number = job_ff.page_number;
                  rsp_in.page_width  = wq_ff;
                  rsp_in.page_height = quo_in;
                  rsp_in.final_page  = job_ff.final_page;
                  state_in = BK_OUT;
               end
            end
         end
         BK_OUT: begin
            if (rsp_ready) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= BK_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      dvd_ff    <= dvd_in;
      quo_ff    <= quo_in;
      wq_ff     <= wq_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      second_ff <= second_in;
      rsp_ff    <= rsp_in;
   end

endmodule

/* hdl/djps_checker.sv */
// djps_port_checker: port-level assertions on the scanner's responses, bound to
// the top level; depends on djps_pkg
module djps_port_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input djps_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input djps_pkg::rsp_type rsp_data
);
   import djps_pkg::*;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_PAGE |->
         rsp_data.page_width == '0 && rsp_data.page_height == '0 && !rsp_data.final_page)
      else $error("error response with non-zero size");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_SHORT)
      else $error("response status out of range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response after reset");

endmodule

bind djvu_page_size_scanner djps_port_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* dv/djps_checker.sv */
// djps_checker: watches the request, response and csr channels of the page size
// scanner, predicts every response and compares; depends on djps_pkg
`timescale 1ns / 1ps
module djps_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  djps_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  djps_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data,
   output int                fail_count,
   output int                pending,
   output int                seen
);
   import djps_pkg::*;

   logic [15:0] page_count_q;
   logic [10:0] ref_dpi_q;
   logic [31:0] pos_q;
   logic [31:0] hdr_q;
   logic [7:0]  win [32];
   logic [15:0] found;
   phase_type   phase;
   bit          done;
   rsp_type     sizes_due [$];
   rsp_type     next_rsp;
   bit          have_rsp;

   function automatic logic [7:0] byte_at(logic [31:0] p);
      return win[p[4:0]];
   endfunction

   function automatic logic [31:0] word_at(logic [31:0] p);
      return {byte_at(p), byte_at(p + 1), byte_at(p + 2), byte_at(p + 3)};
   endfunction

   task automatic clear_scan();
      pos_q = '0;
      hdr_q = '0;
      found = '0;
      phase = PH_SIG;
      done  = 0;
      foreach (win[i]) win[i] = '0;
   endtask

   task automatic stop_scan();
      done  = 1;
      phase = PH_DONE;
   endtask

   task automatic raise_error(input logic [2:0] code);
      next_rsp = '0;
      next_rsp.status = code;
      next_rsp.page_number = found;
      have_rsp = 1;
      stop_scan();
   endtask

   // skip header, body and pad byte; refuse when the next header would not fit
   task automatic step_over(input logic [31:0] h, input logic [31:0] len, output bit ok);
      logic [63:0] nxt;
      nxt = 64'(h) + 64'd8 + 64'(len) + 64'(len[0]);
      ok = (nxt + 64'd30) <= 64'hFFFF_FFFF;
      if (ok) begin
         hdr_q = nxt[31:0];
         phase = PH_HDR;
      end
   endtask

   task automatic scan_byte(input logic [7:0] b);
      logic [31:0] p, h, len;
      logic [15:0] w, ht, dpi;
      logic [7:0]  flags;
      logic [63:0] pw, ph;
      bit          ok, fin, is_page;
      p = pos_q;
      h = hdr_q;
      win[p[4:0]] = b;
      if (pos_q != 32'hFFFF_FFFF) pos_q++;
      case (phase)
         PH_SIG: if (p == SIG_LAST_POS) begin
            if (word_at(0) != TAG_MAGIC || word_at(4) != TAG_FORM) begin
               raise_error(ST_BAD_SIG);
            end else begin
               hdr_q = (word_at(12) == TAG_DJVM) ? 32'd16 : 32'd4;
               phase = PH_HDR;
               if (found >= page_count_q) stop_scan();
            end
         end
         PH_HDR: if (p == h + 15) begin
            if (found >= page_count_q) begin
               stop_scan();
            end else begin
               len = word_at(h + 4);
               is_page = word_at(h) == TAG_FORM && word_at(h + 8) == TAG_DJVU &&
                         word_at(h + 12) == TAG_INFO;
               if (len[31]) raise_error(ST_NEG_LEN);
               else if (is_page) begin
                  if (len < MIN_PAGE_LEN) raise_error(ST_SHORT);
                  else phase = PH_INFO;
               end else begin
                  step_over(h, len, ok);
                  if (!ok) raise_error(ST_EARLY_END);
               end
            end
         end
         PH_INFO: if (p == h + 29) begin
            len   = word_at(h + 4);
            w     = {byte_at(h + 20), byte_at(h + 21)};
            ht    = {byte_at(h + 22), byte_at(h + 23)};
            dpi   = {byte_at(h + 27), byte_at(h + 26)};   // little-endian
            flags = byte_at(h + 29);
            if (dpi == 0) begin
               raise_error(ST_ZERO_DPI);
            end else begin
               step_over(h, len, ok);
               if (!ok) raise_error(ST_EARLY_END);
               else begin
                  pw  = (64'(ref_dpi_q) * 64'(w) * 64'd16) / 64'(dpi);
                  ph  = (64'(ref_dpi_q) * 64'(ht) * 64'd16) / 64'(dpi);
                  fin = (32'(found) + 1) >= 32'(page_count_q);
                  next_rsp = '0;
                  next_rsp.status      = ST_PAGE;
                  next_rsp.page_number = found;
                  next_rsp.page_width  = flags[2] ? ph[30:0] : pw[30:0];
                  next_rsp.page_height = flags[2] ? pw[30:0] : ph[30:0];
                  next_rsp.final_page  = fin;
                  have_rsp = 1;
                  found++;
                  if (fin) stop_scan();
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic take_request(input logic [7:0] b, input logic last);
      have_rsp = 0;
      if (!done) scan_byte(b);
      if (last) begin
         // file ended before enough pages: early end replaces a non-final page
         if (!(done || (phase != PH_SIG && found >= page_count_q))) begin
            next_rsp = '0;
            next_rsp.status = ST_EARLY_END;
            next_rsp.page_number = found;
            have_rsp = 1;
         end
         clear_scan();
      end
      if (have_rsp) sizes_due.push_back(next_rsp);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         page_count_q = 16'd1;
         ref_dpi_q    = 11'd300;
         clear_scan();
         sizes_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == 2'(REG_PAGE_COUNT)) page_count_q = csr_data;
            else if (csr_index == 2'(REG_REF_DPI)) ref_dpi_q = csr_data[10:0];
         end
         if (req_valid && req_ready) take_request(req_data.data_byte, req_data.last_byte);
         if (rsp_valid && rsp_ready) begin
            seen++;
            if (sizes_due.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response %p", $realtime, rsp_data);
            end else begin
               want = sizes_due.pop_front();
               if (rsp_data !== want) begin
                  fail_count++;
                  $display("%0t: mismatch expected %p actual %p", $realtime, want, rsp_data);
               end
            end
         end
      end
      pending = sizes_due.size();
   end

   initial begin
      fail_count = 0;
      pending    = 0;
      seen       = 0;
   end

endmodule

/* dv/djvu_page_size_scanner_tb.sv */
// djvu_page_size_scanner_tb: builds random and broken djvu files as byte requests,
// programs the csr registers between phases and gives the verdict; depends on
// djps_pkg, djps_checker and the scanner rtl
`timescale 1ns / 1ps
module djvu_page_size_scanner_tb;
   import djps_pkg::*;

   // kinds of file the generator can build
   typedef enum int {
      F_RANDOM, F_BAD_SIG, F_NEG_LEN, F_SHORT, F_ZERO_DPI, F_TRUNC
   } file_kind_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   rsp_type     rsp_data;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;
   int          fail_count, pending, seen;

   logic [7:0]  file_q [$];
   int          burst_left = 0;
   int          bytes_sent = 0;
   int          cycle_no = 0;

   always #5 clock = ~clock;

   djvu_page_size_scanner u_dut (.*);

   djps_checker u_checker (.*);

   // receiver: the stall pattern rotates through four modes, one of which never stalls
   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
      case ((cycle_no / 200) % 4)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 3) != 0);
         2:       rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= cycle_no[3];
      endcase
   end

   task automatic push32(input logic [31:0] v);
      file_q.push_back(v[31:24]);
      file_q.push_back(v[23:16]);
      file_q.push_back(v[15:8]);
      file_q.push_back(v[7:0]);
   endtask

   // 16-bit value with the extremes well represented
   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'd1;
         default: return 16'($urandom);
      endcase
   endfunction

   // FORM:DJVU page with its INFO chunk, body padded to even length
   task automatic push_page(input file_kind_type kind);
      logic [31:0] len;
      logic [15:0] dpi;
      len = 22 + $urandom_range(0, 9);
      if (kind == F_SHORT) len = $urandom_range(0, 21);
      if (kind == F_NEG_LEN) len = 32'h8000_0000 | $urandom;
      dpi = pick16();
      if (kind == F_ZERO_DPI) dpi = '0;
      else if (dpi == 0 && $urandom_range(0, 3) != 0) dpi = 16'd300;
      push32(TAG_FORM);
      push32(len);
      push32(TAG_DJVU);
      push32(TAG_INFO);
      push32(32'd10);
      push32({pick16(), pick16()});
      file_q.push_back(8'd26);
      file_q.push_back(8'd0);
      file_q.push_back(dpi[7:0]);
      file_q.push_back(dpi[15:8]);
      file_q.push_back(8'd22);
      file_q.push_back(8'($urandom));
      // short and negative lengths carry no further body
      if (!len[31] && len >= 32'd22)
         repeat (len - 32'd22 + 32'(len[0])) file_q.push_back(8'($urandom));
   endtask

   // any other chunk; the id is sometimes FORM so the walker must check deeper
   task automatic push_other();
      logic [31:0] len;
      len = $urandom_range(0, 20);
      if ($urandom_range(0, 3) == 0) push32(TAG_FORM);
      else push32($urandom);
      push32(len);
      repeat (len + len[0]) file_q.push_back(8'($urandom));
   endtask

   task automatic make_file(input file_kind_type kind);
      int n;
      file_q.delete();
      push32(TAG_MAGIC);
      if ($urandom_range(0, 1)) begin
         // bundled document
         push32(TAG_FORM);
         push32($urandom_range(0, 4000));
         push32(TAG_DJVM);
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 7) push_page(i == n - 1 ? kind : F_RANDOM);
            else push_other();
         end
      end else begin
         push_page(kind);
         if ($urandom_range(0, 3) == 0) push_other();
      end
      if (kind == F_BAD_SIG) file_q[$urandom_range(0, 7)] ^= 8'(1 << $urandom_range(0, 7));
      if (kind == F_TRUNC) begin
         n = $urandom_range(1, file_q.size() - 1);
         while (file_q.size() > n) void'(file_q.pop_back());
      end
      if (kind == F_RANDOM && $urandom_range(0, 9) == 0)
         file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom);
   endtask

   // sender in bursts with random gaps; valid held until the request is taken
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, last_byte: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      bytes_sent++;
   endtask

   task automatic send_file(input file_kind_type kind);
      make_file(kind);
      foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
   endtask

   // registers only change once the scanner has drained
   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [15:0] pages, input logic [15:0] dpi, input int budget);
      int start;
      write_csr(2'(REG_PAGE_COUNT), pages);
      write_csr(2'(REG_REF_DPI), dpi);
      start = bytes_sent;
      while (bytes_sent - start < budget) send_file(F_RANDOM);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: each error, default registers
      send_file(F_RANDOM);
      send_file(F_BAD_SIG);
      send_file(F_NEG_LEN);
      send_file(F_SHORT);
      send_file(F_ZERO_DPI);
      send_file(F_TRUNC);

      // random phases across the register range, extremes included
      run_phase(16'd2, 16'd1200, 250);
      run_phase(16'd65535, 16'd1, 200);
      run_phase(16'd0, 16'd2047, 100);
      run_phase(16'd3, 16'd0, 200);
      run_phase(16'd1, 16'd300, 250);
      run_phase(16'($urandom_range(1, 4)), 16'($urandom_range(1, 1200)), 250);
      while (seen < 60) send_file(F_RANDOM);

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (fail_count == 0)
         $display("djvu_page_size_scanner verification clean");
      else
         $display("djvu_page_size_scanner verification failed");
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("djvu_page_size_scanner verification failed");
      $finish;
   end

endmodule

/* djvu_page_size_scanner.f */
hdl/djps_pkg.sv
hdl/djps_front.sv
hdl/djps_queue.sv
hdl/djps_back.sv
hdl/djvu_page_size_scanner.sv
hdl/djps_checker.sv
dv/djps_checker.sv
dv/djvu_page_size_scanner_tb.sv
